// File: rtl/core/ipau_pkg.sv
`timescale 1ns / 1ps

package ipau_pkg;

	localparam int unsigned AddrW  = 128;
	localparam int unsigned HalfW  = 64;
	localparam int unsigned OpW    = 3;
	localparam int unsigned LenW   = 8;
	localparam int unsigned ClassW = 3;

	// operation codes
	localparam logic [OpW-1:0] OP_CLASSIFY = 3'd0;
	localparam logic [OpW-1:0] OP_MASK     = 3'd1;
	localparam logic [OpW-1:0] OP_COMPARE  = 3'd2;
	localparam logic [OpW-1:0] OP_AND      = 3'd3;
	localparam logic [OpW-1:0] OP_OR       = 3'd4;
	localparam logic [OpW-1:0] OP_XOR      = 3'd5;

	// address classes
	localparam logic [ClassW-1:0] CLS_UNSPEC    = 3'd0;
	localparam logic [ClassW-1:0] CLS_LOOPBACK  = 3'd1;
	localparam logic [ClassW-1:0] CLS_LINKLOCAL = 3'd2;
	localparam logic [ClassW-1:0] CLS_MULTICAST = 3'd3;
	localparam logic [ClassW-1:0] CLS_BROADCAST = 3'd4;
	localparam logic [ClassW-1:0] CLS_PRIVATE   = 3'd5;
	localparam logic [ClassW-1:0] CLS_GLOBAL    = 3'd6;

	// longest legal prefix
	localparam logic [LenW-1:0] MAX_PREFIX = 8'd128;

	// ::ffff:0:0/96, upper word of the low half
	localparam logic [31:0] MAPPED_TAG = 32'h0000_FFFF;

	typedef struct packed {
		logic              is_v4;
		logic [ClassW-1:0] cls;
	} ipau_class_t;

	typedef struct packed {
		logic match;
		logic len_err;
	} ipau_flags_t;

	function automatic logic is_mapped(input logic [AddrW-1:0] addr);
		is_mapped = (addr[AddrW-1:HalfW] == '0) && (addr[HalfW-1:32] == MAPPED_TAG);
	endfunction

endpackage

// File: rtl/core/ip_address_unit.sv
`timescale 1ns / 1ps
// A request is taken into the input register, then into the result register, which drives done.
// Throughput: one request per cycle; busy is held low, so start is taken every cycle.
// The receiver cannot stall: each result is shown for exactly one cycle with done.
// Reset (arst_n low, asynchronous) clears the valid flags of both register stages;
// payload registers are not reset.

module ip_address_unit
	import ipau_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [OpW-1:0]    opcode,
	input  logic [HalfW-1:0]  addr_a_hi,
	input  logic [HalfW-1:0]  addr_a_lo,
	input  logic [HalfW-1:0]  addr_b_hi,
	input  logic [HalfW-1:0]  addr_b_lo,
	input  logic [LenW-1:0]   prefix_len,
	output logic              done,
	output logic [HalfW-1:0]  result_hi,
	output logic [HalfW-1:0]  result_lo,
	output logic              prefix_match,
	output logic              addr_is_v4,
	output logic [ClassW-1:0] addr_class,
	output logic              length_error
);

	// Stage 1: input register. Every request is captured as it arrives.
	logic              valid_s1;
	logic [OpW-1:0]    opcode_s1;
	logic [AddrW-1:0]  addr_a_s1;
	logic [AddrW-1:0]  addr_b_s1;
	logic [LenW-1:0]   len_s1;

	// Stage 2: result register, driving the outputs directly.
	logic              valid_s2;
	logic [AddrW-1:0]  result_s2;
	ipau_flags_t       flags_s2;
	ipau_class_t       class_s2;

	ipau_class_t       class_info;
	ipau_flags_t       op_flags;
	logic [AddrW-1:0]  op_result;
	logic              accept;

	// No busy state and a single pass, so the unit never pushes back.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_s1 <= opcode;
			addr_a_s1 <= {addr_a_hi, addr_a_lo};
			addr_b_s1 <= {addr_b_hi, addr_b_lo};
			len_s1    <= prefix_len;
		end
	end

	// Class and v4 flag of A, reported for every opcode.
	ipau_classify u_classify (
		.addr (addr_a_s1),
		.info (class_info)
	);

	// Opcode-selected operation: mask, compare, and bytewise logic.
	ipau_op u_op (
		.opcode     (opcode_s1),
		.addr_a     (addr_a_s1),
		.addr_b     (addr_b_s1),
		.prefix_len (len_s1),
		.result     (op_result),
		.flags      (op_flags)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_s2 <= op_result;
			flags_s2  <= op_flags;
			class_s2  <= class_info;
		end
	end

	assign done         = valid_s2;
	assign result_hi    = result_s2[AddrW-1:HalfW];
	assign result_lo    = result_s2[HalfW-1:0];
	assign prefix_match = flags_s2.match;
	assign length_error = flags_s2.len_err;
	assign addr_is_v4   = class_s2.is_v4;
	assign addr_class   = class_s2.cls;

	// A strobe only ever follows a request taken through the input and result registers.
	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 2))
		else $error("done without a request two cycles earlier");

	// Length errors only come from mask or compare with an over-long prefix.
	a_len_err_source: assert property (@(posedge clk) disable iff (!arst_n)
		(done && length_error) |-> ($past(prefix_len, 2) > MAX_PREFIX &&
		($past(opcode, 2) == OP_MASK || $past(opcode, 2) == OP_COMPARE)))
		else $error("length_error raised for a legal request");

	// A match is never reported alongside a length error.
	a_match_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(prefix_match && length_error))
		else $error("prefix_match and length_error both set");

	// Match only for compare requests.
	a_match_compare_only: assert property (@(posedge clk) disable iff (!arst_n)
		(done && prefix_match) |-> $past(opcode, 2) == OP_COMPARE)
		else $error("prefix_match outside compare");

endmodule

// File: rtl/core/ipau_classify.sv
`timescale 1ns / 1ps

module ipau_classify
	import ipau_pkg::*;
(
	input  logic [AddrW-1:0] addr,
	output ipau_class_t      info
);

	logic       v4;
	logic [7:0] b0, b1, b12, b13;

	assign v4  = is_mapped(addr);
	assign b0  = addr[127:120];
	assign b1  = addr[119:112];
	assign b12 = addr[31:24];
	assign b13 = addr[23:16];

	always_comb begin
		info.is_v4 = v4;
		if (v4) begin
			// only the embedded v4 address counts
			if (addr[31:0] == '0)
				info.cls = CLS_UNSPEC;
			else if (b12 == 8'd127)
				info.cls = CLS_LOOPBACK;
			else if (b12 == 8'd169 && b13 == 8'd254)
				info.cls = CLS_LINKLOCAL;
			else if (b12 inside {[8'd224:8'd239]})
				info.cls = CLS_MULTICAST;
			else if (addr[31:0] == '1)
				info.cls = CLS_BROADCAST;
			else if (b12 == 8'd10 || (b12 == 8'd172 && b13 inside {[8'd16:8'd31]}) ||
			         (b12 == 8'd192 && b13 == 8'd168))
				info.cls = CLS_PRIVATE;
			else
				info.cls = CLS_GLOBAL;
		end else begin
			if (addr == '0)
				info.cls = CLS_UNSPEC;
			else if (addr == {{(AddrW-1){1'b0}}, 1'b1})
				info.cls = CLS_LOOPBACK;
			else if (b0 == 8'hFE && b1[7:6] == 2'b10)
				info.cls = CLS_LINKLOCAL;
			else if (b0 == 8'hFF)
				info.cls = CLS_MULTICAST;
			else if (b0 inside {8'hFC, 8'hFD})
				info.cls = CLS_PRIVATE;
			else
				info.cls = CLS_GLOBAL;
		end
	end

endmodule

// File: rtl/core/ipau_op.sv
`timescale 1ns / 1ps

module ipau_op
	import ipau_pkg::*;
(
	input  logic [OpW-1:0]   opcode,
	input  logic [AddrW-1:0] addr_a,
	input  logic [AddrW-1:0] addr_b,
	input  logic [LenW-1:0]  prefix_len,
	output logic [AddrW-1:0] result,
	output ipau_flags_t      flags
);

	logic [AddrW-1:0] ones;
	logic [AddrW-1:0] mask;
	logic             len_bad;
	logic             any_v4;

	assign ones    = '1;
	// top prefix_len bits set; all ones at 128
	assign mask    = ~(ones >> prefix_len);
	assign len_bad = prefix_len > MAX_PREFIX;
	assign any_v4  = is_mapped(addr_a) || is_mapped(addr_b);

	always_comb begin
		result        = addr_a;
		flags.match   = 1'b0;
		flags.len_err = 1'b0;
		case (opcode)
			OP_MASK: begin
				if (len_bad)
					flags.len_err = 1'b1;
				else
					result = addr_a & mask;
			end
			OP_COMPARE: begin
				if (len_bad)
					flags.len_err = 1'b1;
				else
					flags.match = ((addr_a ^ addr_b) & mask) == '0;
			end
			OP_AND: result = addr_a & addr_b;
			OP_OR:  result = addr_a | addr_b;
			OP_XOR: begin
				if (any_v4)
					result = addr_a ^ {{(AddrW-32){1'b0}}, addr_b[31:0]};
				else
					result = addr_a ^ addr_b;
			end
			default: result = addr_a;
		endcase
	end

endmodule

// File: test/ip_address_unit_tb.sv
`timescale 1ns / 1ps

module ip_address_unit_tb;
	import ipau_pkg::*;

	localparam int          CYCLE_LIMIT   = 200000;
	localparam int          RANDOM_COUNT  = 1400;
	localparam int          DRAIN_CYCLES  = 8;
	localparam logic [63:0] ONES64        = 64'hffff_ffff_ffff_ffff;

	// one result as it appears on the output ports
	typedef struct packed {
		logic [HalfW-1:0]  hi;
		logic [HalfW-1:0]  lo;
		logic              match;
		logic              v4;
		logic [ClassW-1:0] cls;
		logic              len_err;
	} addr_result_t;

	// one request; known marks a row whose result is typed in by hand
	typedef struct packed {
		logic [OpW-1:0]   op;
		logic [AddrW-1:0] a;
		logic [AddrW-1:0] b;
		logic [LenW-1:0]  len;
		logic             known;
		addr_result_t     res;
	} request_t;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              start        = 1'b0;
	logic              busy;
	logic [OpW-1:0]    opcode       = '0;
	logic [HalfW-1:0]  addr_a_hi    = '0;
	logic [HalfW-1:0]  addr_a_lo    = '0;
	logic [HalfW-1:0]  addr_b_hi    = '0;
	logic [HalfW-1:0]  addr_b_lo    = '0;
	logic [LenW-1:0]   prefix_len   = '0;
	logic              done;
	logic [HalfW-1:0]  result_hi;
	logic [HalfW-1:0]  result_lo;
	logic              prefix_match;
	logic              addr_is_v4;
	logic [ClassW-1:0] addr_class;
	logic              length_error;

	// travels alongside the request so the scoreboard knows a hand-typed result
	logic              cur_known    = 1'b0;
	addr_result_t      cur_expected = '0;

	addr_result_t pending_results[$];
	request_t     directed_rows[$];
	int           fault_count   = 0;
	int           accepted      = 0;
	int           results_seen  = 0;
	int           cycle_count;
	int           op_seen[8];
	int           class_seen[8];

	ip_address_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.addr_a_hi    (addr_a_hi),
		.addr_a_lo    (addr_a_lo),
		.addr_b_hi    (addr_b_hi),
		.addr_b_lo    (addr_b_lo),
		.prefix_len   (prefix_len),
		.done         (done),
		.result_hi    (result_hi),
		.result_lo    (result_lo),
		.prefix_match (prefix_match),
		.addr_is_v4   (addr_is_v4),
		.addr_class   (addr_class),
		.length_error (length_error)
	);

	always #6 clk = ~clk;

	// ::ffff:a.b.c.d
	function automatic logic [AddrW-1:0] mapped(input logic [31:0] ip);
		return {64'h0, MAPPED_TAG, ip};
	endfunction

	function automatic logic is_v4_mapped(input logic [AddrW-1:0] x);
		return (x[127:64] == '0) && (x[63:32] == MAPPED_TAG);
	endfunction

	// class of an address; v4 tests look only at the last four bytes
	function automatic logic [ClassW-1:0] address_class(input logic [AddrW-1:0] x);
		logic [7:0]  b0;
		logic [7:0]  b1;
		logic [7:0]  b12;
		logic [7:0]  b13;
		logic [31:0] w;
		b0  = x[127:120];
		b1  = x[119:112];
		b12 = x[31:24];
		b13 = x[23:16];
		w   = x[31:0];
		if (is_v4_mapped(x)) begin
			if (w == '0)
				return CLS_UNSPEC;
			if (b12 == 8'd127)
				return CLS_LOOPBACK;
			if (b12 == 8'd169 && b13 == 8'd254)
				return CLS_LINKLOCAL;
			if (b12 >= 8'd224 && b12 <= 8'd239)
				return CLS_MULTICAST;
			if (&w)
				return CLS_BROADCAST;
			if (b12 == 8'd10 || (b12 == 8'd172 && b13 >= 8'd16 && b13 <= 8'd31) ||
			    (b12 == 8'd192 && b13 == 8'd168))
				return CLS_PRIVATE;
			return CLS_GLOBAL;
		end
		if (x == '0)
			return CLS_UNSPEC;
		if (x == 128'd1)
			return CLS_LOOPBACK;
		if (b0 == 8'hfe && b1[7:6] == 2'b10)
			return CLS_LINKLOCAL;
		if (b0 == 8'hff)
			return CLS_MULTICAST;
		if (b0 == 8'hfc || b0 == 8'hfd)
			return CLS_PRIVATE;
		return CLS_GLOBAL;
	endfunction

	// what the unit should produce for one request
	function automatic addr_result_t address_result(input logic [OpW-1:0] op,
			input logic [AddrW-1:0] a, input logic [AddrW-1:0] b,
			input logic [LenW-1:0] len);
		addr_result_t r;
		logic [AddrW-1:0] m;
		logic [AddrW-1:0] y;
		y         = a;
		r         = '0;
		// shift by the full width leaves zero, which covers a length of zero
		m         = (len > MAX_PREFIX) ? '1 : ({AddrW{1'b1}} << (AddrW - int'(len)));
		case (op)
			OP_MASK: begin
				if (len > MAX_PREFIX)
					r.len_err = 1'b1;
				else
					y = a & m;
			end
			OP_COMPARE: begin
				if (len > MAX_PREFIX)
					r.len_err = 1'b1;
				else
					r.match = (((a ^ b) & m) == '0);
			end
			OP_AND: y = a & b;
			OP_OR:  y = a | b;
			OP_XOR: begin
				// a v4 operand on either side limits xor to the last four bytes
				if (is_v4_mapped(a) || is_v4_mapped(b))
					y = a ^ {96'h0, b[31:0]};
				else
					y = a ^ b;
			end
			default: ;
		endcase
		r.hi  = y[127:64];
		r.lo  = y[63:0];
		r.v4  = is_v4_mapped(a);
		r.cls = address_class(a);
		return r;
	endfunction

	// addresses steered towards every class and near-miss of the v4 tag
	function automatic logic [AddrW-1:0] random_address();
		logic [AddrW-1:0] x;
		x = {$urandom, $urandom, $urandom, $urandom};
		case ($urandom_range(0, 9))
			0, 1: begin
				x[127:32] = {64'h0, MAPPED_TAG};
				case ($urandom_range(0, 7))
					0: x[31:0]  = '0;
					1: x[31:24] = 8'd127;
					2: begin
						x[31:24] = 8'd169;
						if ($urandom_range(0, 2) != 0)
							x[23:16] = 8'd254;
					end
					3: x[31:24] = 8'($urandom_range(223, 240));
					4: x[31:0]  = '1;
					5: x[31:24] = 8'd10;
					6: begin
						x[31:24] = 8'd172;
						x[23:16] = 8'($urandom_range(14, 33));
					end
					default: begin
						x[31:24] = 8'd192;
						if ($urandom_range(0, 2) != 0)
							x[23:16] = 8'd168;
					end
				endcase
			end
			2: x = AddrW'($urandom_range(0, 3));
			3: x[127:120] = 8'hfe;
			4: x[127:120] = 8'hff;
			5: x[127:120] = 8'($urandom_range(8'hfb, 8'hfe));
			// v4 tag with one bit spoiled
			6: x[127:32] = {64'h0, MAPPED_TAG ^ (32'h1 << $urandom_range(0, 31))};
			default: ;
		endcase
		return x;
	endfunction

	function automatic request_t random_request();
		request_t r;
		int       k;
		r       = '0;
		k       = -1;
		r.op    = ($urandom_range(0, 19) == 0) ? OpW'($urandom_range(6, 7))
		                                       : OpW'($urandom_range(0, 5));
		r.a     = random_address();
		case ($urandom_range(0, 7))
			0, 1, 2, 3: r.b = random_address();
			4, 5, 6: begin
				// one bit apart: compare flips right at the prefix boundary
				k   = $urandom_range(0, 127);
				r.b = r.a ^ (128'h1 << k);
			end
			default: r.b = r.a;
		endcase
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: r.len = LenW'($urandom_range(0, 128));
			6: r.len = ($urandom_range(0, 2) == 0) ? 8'd0 :
			           ($urandom_range(0, 1) == 0) ? 8'd64 : MAX_PREFIX;
			7: r.len = LenW'($urandom_range(129, 255));
			default: r.len = (k >= 0) ? LenW'(127 - k + $urandom_range(0, 1))
			                          : LenW'($urandom_range(0, 128));
		endcase
		return r;
	endfunction

	task automatic row_pred(input logic [OpW-1:0] op, input logic [AddrW-1:0] a,
			input logic [AddrW-1:0] b, input logic [LenW-1:0] len);
		directed_rows.push_back({op, a, b, len, 1'b0, addr_result_t'('0)});
	endtask

	task automatic row_known(input logic [OpW-1:0] op, input logic [AddrW-1:0] a,
			input logic [AddrW-1:0] b, input logic [LenW-1:0] len,
			input addr_result_t res);
		directed_rows.push_back({op, a, b, len, 1'b1, res});
	endtask

	// present one request and hold it until taken; idx picks the quiet stretch
	task automatic issue(input request_t r, input int idx);
		if (!(idx >= 500 && idx < 850) && $urandom_range(0, 99) < 6) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start        <= 1'b1;
		opcode       <= r.op;
		addr_a_hi    <= r.a[127:64];
		addr_a_lo    <= r.a[63:0];
		addr_b_hi    <= r.b[127:64];
		addr_b_lo    <= r.b[63:0];
		prefix_len   <= r.len;
		cur_known    <= r.known;
		cur_expected <= r.res;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// results are checked before the request of the same edge is queued;
	// since every result passes both register stages, the order is never in doubt
	always @(posedge clk) begin : scoreboard
		addr_result_t got;
		addr_result_t want;
		logic [AddrW-1:0] a_now;
		a_now = {addr_a_hi, addr_a_lo};
		if (done) begin
			got = {result_hi, result_lo, prefix_match, addr_is_v4, addr_class, length_error};
			results_seen++;
			if (pending_results.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("%0t: result with no request outstanding: hi=%h lo=%h",
					         $realtime, result_hi, result_lo);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					fault_count++;
					if (fault_count <= 10) begin
						$display("%0t: mismatch on result %0d", $realtime, results_seen);
						$display("  expected hi=%h lo=%h match=%b v4=%b class=%0d err=%b",
						         want.hi, want.lo, want.match, want.v4, want.cls,
						         want.len_err);
						$display("  actual   hi=%h lo=%h match=%b v4=%b class=%0d err=%b",
						         got.hi, got.lo, got.match, got.v4, got.cls, got.len_err);
					end
				end
			end
		end
		if (arst_n && start && !busy) begin
			pending_results.push_back(cur_known ? cur_expected :
				address_result(opcode, a_now, {addr_b_hi, addr_b_lo}, prefix_len));
			accepted++;
			op_seen[opcode]++;
			class_seen[address_class(a_now)]++;
		end
	end

	initial begin : watchdog
		for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
			@(posedge clk);
		$display("ip_address_unit regression: fail");
		$finish;
	end

	initial begin : stimulus
		request_t r;
		int       n;
		foreach (op_seen[i]) begin
			op_seen[i]    = 0;
			class_seen[i] = 0;
		end

		// classes of plain and v4-mapped addresses
		row_known(OP_CLASSIFY, '0, '1, 8'd0,
		          {64'h0, 64'h0, 1'b0, 1'b0, CLS_UNSPEC, 1'b0});
		row_known(OP_CLASSIFY, 128'd1, '0, 8'd0,
		          {64'h0, 64'h1, 1'b0, 1'b0, CLS_LOOPBACK, 1'b0});
		row_known(OP_CLASSIFY, '1, '0, 8'd255,
		          {ONES64, ONES64, 1'b0, 1'b0, CLS_MULTICAST, 1'b0});
		row_known(OP_CLASSIFY, mapped(32'hffff_ffff), '0, 8'd0,
		          {64'h0, 64'h0000_ffff_ffff_ffff, 1'b0, 1'b1, CLS_BROADCAST, 1'b0});
		row_pred(OP_CLASSIFY, {16'hfe80, 112'h1}, '0, 8'd0);
		row_pred(OP_CLASSIFY, {8'hfd, 120'h5}, '0, 8'd0);
		row_pred(OP_CLASSIFY, {32'h2001_0db8, 96'h1}, '1, 8'd0);
		row_pred(OP_CLASSIFY, mapped(32'h0), '0, 8'd0);

		// mask: empty, full and over-long prefixes
		row_known(OP_MASK, '1, '0, 8'd0,
		          {64'h0, 64'h0, 1'b0, 1'b0, CLS_MULTICAST, 1'b0});
		row_known(OP_MASK, '1, '0, MAX_PREFIX,
		          {ONES64, ONES64, 1'b0, 1'b0, CLS_MULTICAST, 1'b0});
		row_known(OP_MASK, '1, '0, 8'd129,
		          {ONES64, ONES64, 1'b0, 1'b0, CLS_MULTICAST, 1'b1});
		row_known(OP_MASK, '0, '1, 8'd255,
		          {64'h0, 64'h0, 1'b0, 1'b0, CLS_UNSPEC, 1'b1});
		row_pred(OP_MASK, mapped(32'h7f00_0001), '0, 8'd65);

		// compare: zero length always matches, over-long never does
		row_known(OP_COMPARE, '0, '1, 8'd0,
		          {64'h0, 64'h0, 1'b1, 1'b0, CLS_UNSPEC, 1'b0});
		row_known(OP_COMPARE, '1, '1, 8'd129,
		          {ONES64, ONES64, 1'b0, 1'b0, CLS_MULTICAST, 1'b1});
		row_pred(OP_COMPARE, mapped(32'ha9fe_0101), mapped(32'ha9fe_0101), MAX_PREFIX);

		// bytewise ops, xor with and without a v4 operand, unused codes
		row_pred(OP_AND, mapped(32'he000_0001), '1, 8'd0);
		row_pred(OP_OR, mapped(32'h0a01_0203), {32'h1234_5678, 96'h9abc}, 8'd0);
		row_pred(OP_XOR, {8'hfd, 120'h5a5a}, '1, 8'd0);
		row_pred(OP_XOR, mapped(32'hc0a8_0101), {32'h0123_4567, 96'h89ab_cdef_55aa}, 8'd0);
		row_pred(OpW'(6), mapped(32'hac10_0001), '1, 8'd200);
		row_pred(OpW'(7), mapped(32'h0808_0808), '1, MAX_PREFIX);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			issue(directed_rows[i], 0);
		for (n = 0; n < RANDOM_COUNT; n++) begin
			r = random_request();
			issue(r, n);
		end
		start <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("requests %0d (%0d typed rows), results %0d, faults %0d",
		         accepted, directed_rows.size(), results_seen, fault_count);
		$display("ops 0..7: %0d %0d %0d %0d %0d %0d %0d %0d; classes 0..6: %0d %0d %0d %0d %0d %0d %0d",
		         op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4], op_seen[5],
		         op_seen[6], op_seen[7], class_seen[0], class_seen[1], class_seen[2],
		         class_seen[3], class_seen[4], class_seen[5], class_seen[6]);
		if (fault_count == 0)
			$display("ip_address_unit regression: pass");
		else
			$display("ip_address_unit regression: fail");
		$finish;
	end

endmodule
